// ----- hw/rtl/mlqs_pkg.sv -----
// ----------------------------------------------------------------------------
// mlqs_pkg: shared types and constants of the multilevel queue scheduler
// Operation, state and status codes, the task record and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package mlqs_pkg;

	localparam int DEF_NUM_ENTRIES = 64;
	localparam int NUM_LEVELS      = 3;
	localparam int CFG_COUNT       = 4;

	localparam logic [2:0] OP_TICK      = 3'd0;
	localparam logic [2:0] OP_SCHEDULE  = 3'd1;
	localparam logic [2:0] OP_SET_STATE = 3'd2;
	localparam logic [2:0] OP_SET_BURST = 3'd3;
	localparam logic [2:0] OP_SET_QUEUE = 3'd4;

	localparam logic [2:0] LS_UNUSED   = 3'd0;
	localparam logic [2:0] LS_EMBRYO   = 3'd1;
	localparam logic [2:0] LS_RUNNABLE = 3'd3;
	localparam logic [2:0] LS_RUNNING  = 3'd4;
	localparam logic [2:0] LS_MAX      = 3'd5;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [1:0] STAT_BAD_ARG   = 2'd2;
	localparam logic [1:0] STAT_IN_QUEUE  = 2'd3;

	localparam logic [1:0] CFG_BASE_SLICE = 2'd0;
	localparam logic [1:0] CFG_W_RR       = 2'd1;
	localparam logic [1:0] CFG_W_SF       = 2'd2;
	localparam logic [1:0] CFG_W_FC       = 2'd3;

	localparam logic [1:0] LVL_RR    = 2'd0;
	localparam logic [1:0] LVL_SF    = 2'd1;
	localparam logic [1:0] LVL_FC    = 2'd2;
	localparam logic [1:0] LVL_NEVER = 2'd3;

	localparam logic [9:0]  AGE_LIMIT    = 10'd800;
	localparam logic [9:0]  WAIT_MAX     = 10'd1023;
	localparam logic [2:0]  STREAK_LIMIT = 3'd5;
	localparam logic [2:0]  STREAK_MAX   = 3'd7;
	localparam logic [31:0] LCG_MUL      = 32'd1103515243;
	localparam logic [31:0] LCG_INC      = 32'd12345;
	localparam logic [12:0] RECIP_100    = 13'd5243;
	localparam logic [6:0]  MOD_BASE     = 7'd100;
	localparam logic [6:0]  CONF_INIT    = 7'd50;
	localparam logic [15:0] BURST_INIT   = 16'd2;

	typedef struct packed {
		logic [2:0]  life;
		logic [15:0] tag;
		logic [1:0]  level;
		logic [9:0]  waitc;
		logic [6:0]  conf;
		logic [15:0] burst;
		logic [2:0]  streak;
		logic [31:0] arrival;
	} rec_t;

	localparam rec_t REC_RESET = '{life: LS_UNUSED, tag: 16'd0, level: LVL_RR,
		waitc: 10'd0, conf: CONF_INIT, burst: BURST_INIT, streak: 3'd0,
		arrival: 32'd0};

	localparam logic [4:0] ACT_NONE      = 5'd0;
	localparam logic [4:0] ACT_TICK      = 5'd1;
	localparam logic [4:0] ACT_BAD       = 5'd2;
	localparam logic [4:0] ACT_NOT_FOUND = 5'd3;
	localparam logic [4:0] ACT_AGE       = 5'd4;
	localparam logic [4:0] ACT_YIELD     = 5'd5;
	localparam logic [4:0] ACT_LEVEL     = 5'd6;
	localparam logic [4:0] ACT_CLEAR     = 5'd7;
	localparam logic [4:0] ACT_STICKY0   = 5'd8;
	localparam logic [4:0] ACT_RR        = 5'd9;
	localparam logic [4:0] ACT_STICKY    = 5'd10;
	localparam logic [4:0] ACT_MINKEY    = 5'd11;
	localparam logic [4:0] ACT_MINARR    = 5'd12;
	localparam logic [4:0] ACT_USE_PREV  = 5'd13;
	localparam logic [4:0] ACT_LOT_A     = 5'd14;
	localparam logic [4:0] ACT_LOT_B     = 5'd15;
	localparam logic [4:0] ACT_NEXT_CAND = 5'd16;
	localparam logic [4:0] ACT_MISS      = 5'd17;
	localparam logic [4:0] ACT_GRANT     = 5'd18;
	localparam logic [4:0] ACT_SET_STATE = 5'd19;
	localparam logic [4:0] ACT_FIND      = 5'd20;
	localparam logic [4:0] ACT_SET_BURST = 5'd21;
	localparam logic [4:0] ACT_SET_QUEUE = 5'd22;

	localparam logic [2:0] AS_SCAN  = 3'd0;
	localparam logic [2:0] AS_RR    = 3'd1;
	localparam logic [2:0] AS_RUN   = 3'd2;
	localparam logic [2:0] AS_INPUT = 3'd3;
	localparam logic [2:0] AS_BEST  = 3'd4;

	typedef struct packed {
		logic [4:0] act;
		logic       rd;
		logic [2:0] asel;
		logic       emit;
		logic       load;
	} cmd_t;

	typedef struct packed {
		logic       hit;
		logic       found;
		logic       prev_valid;
		logic       win;
		logic       run_valid;
		logic       last_valid;
		logic       last_level;
		logic       bad_set;
		logic       tag_zero;
		logic [1:0] level;
	} stat_t;

endpackage

// ----- hw/rtl/mlqs_req_if.sv -----
// ----------------------------------------------------------------------------
// mlqs_req_if: request channel of the scheduler
// One beat carries one operation with all of its argument fields.
// ----------------------------------------------------------------------------
interface mlqs_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [5:0]  entry;
	logic [15:0] task_tag;
	logic [2:0]  new_state;
	logic [15:0] burst_value;
	logic [6:0]  confidence_value;
	logic [1:0]  queue_value;

	modport source (output valid, operation, entry, task_tag, new_state, burst_value,
		confidence_value, queue_value, input ready);
	modport sink (input valid, operation, entry, task_tag, new_state, burst_value,
		confidence_value, queue_value, output ready);
endinterface

// ----- hw/rtl/mlqs_rsp_if.sv -----
// ----------------------------------------------------------------------------
// mlqs_rsp_if: response channel of the scheduler
// One beat carries the result of one operation.
// ----------------------------------------------------------------------------
interface mlqs_rsp_if;
	logic        valid;
	logic        ready;
	logic        grant_valid;
	logic [5:0]  grant_entry;
	logic [15:0] grant_tag;
	logic [1:0]  grant_level;
	logic        yield_now;
	logic [1:0]  status;

	modport source (output valid, grant_valid, grant_entry, grant_tag, grant_level,
		yield_now, status, input ready);
	modport sink (input valid, grant_valid, grant_entry, grant_tag, grant_level,
		yield_now, status, output ready);
endinterface

// ----- hw/rtl/mlqs_ram.sv -----
// ----------------------------------------------------------------------------
// mlqs_ram: generic single write, single read RAM
// Read data is registered and appears the cycle after the read enable.
// ----------------------------------------------------------------------------
module mlqs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ----- hw/rtl/mlqs_dp.sv -----
// ----------------------------------------------------------------------------
// mlqs_dp: scheduler datapath
// Task record memory with per-entry valid bits, scalar scheduler state,
// record update logic, search registers, the lottery generator and the
// result and output registers.
// ----------------------------------------------------------------------------
module mlqs_dp #(
	parameter int NUM_ENTRIES = mlqs_pkg::DEF_NUM_ENTRIES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mlqs_pkg::cmd_t                 cmd,
	input  logic [$clog2(NUM_ENTRIES)-1:0] scan_idx,
	output mlqs_pkg::stat_t                stat,
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_index,
	input  logic [7:0]                     cfg_data,
	input  logic [5:0]                     entry,
	input  logic [15:0]                    task_tag,
	input  logic [2:0]                     new_state,
	input  logic [15:0]                    burst_value,
	input  logic [6:0]                     confidence_value,
	input  logic [1:0]                     queue_value,
	output logic                           grant_valid,
	output logic [5:0]                     grant_entry,
	output logic [15:0]                    grant_tag,
	output logic [1:0]                     grant_level,
	output logic                           yield_now,
	output logic [1:0]                     status
);
	import mlqs_pkg::*;

	localparam int IW = $clog2(NUM_ENTRIES);
	localparam int KW = 16 + IW;

	// Captured request fields.
	logic [5:0]  entry_q;
	logic [15:0] tag_q;
	logic [2:0]  ns_q;
	logic [15:0] burst_q;
	logic [6:0]  conf_q;
	logic [1:0]  queue_q;

	logic [7:0]            cfg_q [CFG_COUNT];
	logic [31:0]           tick_q;
	logic [31:0]           seed_q;
	logic [IW-1:0]         rr_q;
	logic [NUM_LEVELS-1:0] last_valid_q;
	logic [15:0]           last_tag_q [NUM_LEVELS];
	logic [1:0]            cl_q;
	logic [15:0]           lrc_q;
	logic                  run_valid_q;
	logic [IW-1:0]         run_idx_q;
	logic [NUM_ENTRIES-1:0] vld_q;

	logic [IW-1:0] best_idx_q;
	logic          best_found_q;
	logic [KW-1:0] best_key_q;
	logic [6:0]    best_conf_q;
	logic [31:0]   best_arr_q;
	logic [KW-1:0] prev_key_q;
	logic          prev_valid_q;
	logic [27:0]   prod_s1;
	logic [14:0]   xs_s1;
	logic [6:0]    rnd_q;

	logic        res_gv_q, res_y_q;
	logic [5:0]  res_ge_q;
	logic [15:0] res_gt_q;
	logic [1:0]  res_gl_q, res_st_q;

	logic [IW-1:0] raddr_s1;
	logic          rvld_s1;
	logic [IW-1:0] raddr, rr_next, ent_idx;
	logic [$bits(rec_t)-1:0] ram_rdata;
	rec_t          rec, wrec;
	logic          we, hit;
	logic          elig0, elig1, elig2, elig_cl, tag_last_cl, tag_last0;
	logic [KW-1:0] cur_key;
	logic [15:0]   lrc_inc, slice;
	logic [7:0]    weight;
	logic          slice_hit, yld;
	logic [9:0]    wait_inc;
	logic [7:0]    ent_ext;
	logic [8:0]    ent_cmp;
	logic [31:0]   seed_sum;
	logic [8:0]    quot;
	logic [15:0]   rem_full;

	assign ent_ext = {2'b00, entry_q};
	assign ent_idx = ent_ext[IW-1:0];
	assign ent_cmp = {3'b000, entry_q};
	assign rr_next = (rr_q == IW'(NUM_ENTRIES - 1)) ? '0 : rr_q + 1'b1;

	always_comb begin
		case (cmd.asel)
			AS_SCAN:  raddr = scan_idx;
			AS_RR:    raddr = rr_next;
			AS_RUN:   raddr = run_idx_q;
			AS_INPUT: raddr = ent_idx;
			AS_BEST:  raddr = best_idx_q;
			default:  raddr = scan_idx;
		endcase
	end

	mlqs_ram #(.WIDTH($bits(rec_t)), .DEPTH(NUM_ENTRIES)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (raddr_s1),
		.wdata (wrec),
		.re    (cmd.rd),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	// An entry never written since reset reads as the reset record.
	assign rec = rvld_s1 ? rec_t'(ram_rdata) : REC_RESET;

	assign elig0       = (rec.life == LS_RUNNABLE) && (rec.level == LVL_RR);
	assign elig1       = (rec.life == LS_RUNNABLE) && (rec.level == LVL_SF);
	assign elig2       = (rec.life == LS_RUNNABLE) && (rec.level == LVL_FC);
	assign elig_cl     = (rec.life == LS_RUNNABLE) && (rec.level == cl_q);
	assign tag_last_cl = rec.tag == last_tag_q[cl_q];
	assign tag_last0   = rec.tag == last_tag_q[LVL_RR];
	assign cur_key     = {rec.burst, raddr_s1};

	always_comb begin
		case (rec.level)
			LVL_RR:  weight = cfg_q[CFG_W_RR];
			LVL_SF:  weight = cfg_q[CFG_W_SF];
			LVL_FC:  weight = cfg_q[CFG_W_FC];
			default: weight = cfg_q[CFG_W_FC];
		endcase
	end

	assign lrc_inc   = lrc_q + 16'd1;
	assign slice     = cfg_q[CFG_BASE_SLICE] * weight;
	assign slice_hit = (rec.level != LVL_NEVER) && (lrc_inc == slice);
	assign yld       = (rec.level == LVL_NEVER) || slice_hit ||
		((rec.level == LVL_RR) && (rec.streak == STREAK_LIMIT));
	assign wait_inc  = (rec.waitc < WAIT_MAX) ? rec.waitc + 10'd1 : rec.waitc;

	always_comb begin
		case (cmd.act)
			ACT_STICKY0: hit = tag_last0 && (rec.streak != STREAK_LIMIT) && elig0;
			ACT_RR:      hit = elig0;
			ACT_STICKY:  hit = elig_cl && tag_last_cl;
			ACT_FIND:    hit = (rec.life != LS_UNUSED) && (rec.tag == tag_q);
			default:     hit = 1'b0;
		endcase
	end

	always_comb begin
		wrec = rec;
		we   = 1'b0;
		case (cmd.act)
			ACT_AGE: begin
				if (rec.life == LS_RUNNABLE) begin
					we         = 1'b1;
					wrec.waitc = wait_inc;
					if ((wait_inc >= AGE_LIMIT) && (rec.level != LVL_RR)) begin
						wrec.level   = rec.level - 2'd1;
						wrec.arrival = tick_q;
						wrec.waitc   = 10'd0;
					end
				end
			end
			ACT_YIELD: begin
				we = 1'b1;
				if (yld) begin
					wrec.life = LS_RUNNABLE;
				end else if (rec.streak < STREAK_MAX) begin
					wrec.streak = rec.streak + 3'd1;
				end
			end
			ACT_STICKY0: begin
				// A task that used up its reuse allowance is reset and passed over.
				if (tag_last0 && (rec.streak == STREAK_LIMIT)) begin
					we          = 1'b1;
					wrec.streak = 3'd0;
				end
			end
			ACT_GRANT: begin
				we          = 1'b1;
				wrec.waitc  = 10'd0;
				wrec.streak = 3'd1;
				wrec.life   = LS_RUNNING;
			end
			ACT_SET_STATE: begin
				we        = 1'b1;
				wrec.life = ns_q;
				wrec.tag  = tag_q;
				if ((ns_q == LS_EMBRYO) || (ns_q == LS_UNUSED)) begin
					wrec.level   = (ns_q == LS_UNUSED) ? LVL_FC : LVL_RR;
					wrec.waitc   = 10'd0;
					wrec.conf    = CONF_INIT;
					wrec.burst   = BURST_INIT;
					wrec.streak  = 3'd0;
					wrec.arrival = tick_q;
				end
			end
			ACT_SET_BURST: begin
				we         = 1'b1;
				wrec.burst = burst_q;
				wrec.conf  = conf_q;
			end
			ACT_SET_QUEUE: begin
				if (rec.level != queue_q) begin
					we           = 1'b1;
					wrec.level   = queue_q;
					wrec.arrival = tick_q;
				end
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	assign seed_sum = seed_q + tick_q;
	assign quot     = prod_s1[27:19];
	assign rem_full = {1'b0, xs_s1} - quot * MOD_BASE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[CFG_BASE_SLICE] <= 8'd1;
			cfg_q[CFG_W_RR]       <= 8'd3;
			cfg_q[CFG_W_SF]       <= 8'd2;
			cfg_q[CFG_W_FC]       <= 8'd1;
			tick_q       <= '0;
			seed_q       <= 32'd1;
			rr_q         <= '0;
			last_valid_q <= '0;
			cl_q         <= LVL_FC;
			lrc_q        <= '0;
			run_valid_q  <= 1'b0;
			vld_q        <= '0;
			rvld_s1      <= 1'b0;
			best_found_q <= 1'b0;
			prev_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q[cfg_index] <= cfg_data;
			end
			if (cmd.rd) begin
				rvld_s1 <= vld_q[raddr];
			end
			if (we) begin
				vld_q[raddr_s1] <= 1'b1;
			end
			case (cmd.act)
				ACT_TICK: tick_q <= tick_q + 32'd1;
				ACT_YIELD: begin
					lrc_q <= slice_hit ? 16'd0 : lrc_inc;
					if (yld) begin
						run_valid_q <= 1'b0;
					end
				end
				ACT_LEVEL: begin
					if (lrc_q == 16'd0) begin
						cl_q <= (cl_q == LVL_FC) ? LVL_RR : cl_q + 2'd1;
					end
				end
				ACT_CLEAR: begin
					best_found_q <= 1'b0;
					prev_valid_q <= 1'b0;
				end
				ACT_STICKY0, ACT_STICKY, ACT_FIND: begin
					if (hit) begin
						best_found_q <= 1'b1;
					end
				end
				ACT_RR: begin
					rr_q <= raddr_s1;
					if (hit) begin
						best_found_q <= 1'b1;
					end
				end
				ACT_MINKEY: begin
					if (elig1 && (!prev_valid_q || (cur_key > prev_key_q)) &&
						(!best_found_q || (cur_key < best_key_q))) begin
						best_found_q <= 1'b1;
					end
				end
				ACT_MINARR: begin
					if (elig2 && (!best_found_q || (rec.arrival < best_arr_q))) begin
						best_found_q <= 1'b1;
					end
				end
				ACT_LOT_A: seed_q <= 32'(seed_sum * LCG_MUL) + LCG_INC;
				ACT_NEXT_CAND: begin
					prev_valid_q <= 1'b1;
					best_found_q <= 1'b0;
				end
				ACT_MISS: begin
					last_valid_q[cl_q] <= 1'b0;
					lrc_q              <= 16'd0;
				end
				ACT_GRANT: begin
					last_valid_q[cl_q] <= 1'b1;
					run_valid_q        <= 1'b1;
				end
				ACT_SET_STATE: begin
					if (run_valid_q && (run_idx_q == raddr_s1) && (ns_q != LS_RUNNING)) begin
						run_valid_q <= 1'b0;
					end
				end
				default: begin
					tick_q <= tick_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			raddr_s1 <= raddr;
		end
		if (cmd.load) begin
			entry_q  <= entry;
			tag_q    <= task_tag;
			ns_q     <= new_state;
			burst_q  <= burst_value;
			conf_q   <= confidence_value;
			queue_q  <= queue_value;
			res_gv_q <= 1'b0;
			res_ge_q <= '0;
			res_gt_q <= '0;
			res_gl_q <= '0;
			res_y_q  <= 1'b0;
			res_st_q <= STAT_OK;
		end
		case (cmd.act)
			ACT_BAD:       res_st_q <= STAT_BAD_ARG;
			ACT_NOT_FOUND: res_st_q <= STAT_NOT_FOUND;
			ACT_YIELD:     res_y_q  <= yld;
			ACT_STICKY0, ACT_RR, ACT_STICKY, ACT_FIND: begin
				if (hit) begin
					best_idx_q <= raddr_s1;
				end
			end
			ACT_MINKEY: begin
				if (elig1 && (!prev_valid_q || (cur_key > prev_key_q)) &&
					(!best_found_q || (cur_key < best_key_q))) begin
					best_idx_q  <= raddr_s1;
					best_key_q  <= cur_key;
					best_conf_q <= rec.conf;
				end
			end
			ACT_MINARR: begin
				if (elig2 && (!best_found_q || (rec.arrival < best_arr_q))) begin
					best_idx_q <= raddr_s1;
					best_arr_q <= rec.arrival;
				end
			end
			ACT_USE_PREV: best_idx_q <= prev_key_q[IW-1:0];
			ACT_LOT_A: begin
				xs_s1   <= seed_q[30:16];
				prod_s1 <= seed_q[30:16] * RECIP_100;
			end
			ACT_LOT_B:     rnd_q      <= rem_full[6:0];
			ACT_NEXT_CAND: prev_key_q <= best_key_q;
			ACT_GRANT: begin
				last_tag_q[cl_q] <= rec.tag;
				run_idx_q        <= raddr_s1;
				res_gv_q         <= 1'b1;
				res_ge_q         <= 6'(raddr_s1);
				res_gt_q         <= rec.tag;
				res_gl_q         <= cl_q;
			end
			ACT_SET_QUEUE: begin
				if (rec.level == queue_q) begin
					res_st_q <= STAT_IN_QUEUE;
				end
			end
			default: begin
				rnd_q <= rnd_q;
			end
		endcase
		if (cmd.emit) begin
			grant_valid <= res_gv_q;
			grant_entry <= res_ge_q;
			grant_tag   <= res_gt_q;
			grant_level <= res_gl_q;
			yield_now   <= res_y_q;
			status      <= res_st_q;
		end
	end

	assign stat.hit        = hit;
	assign stat.found      = best_found_q;
	assign stat.prev_valid = prev_valid_q;
	assign stat.win        = rnd_q < best_conf_q;
	assign stat.run_valid  = run_valid_q;
	assign stat.last_valid = last_valid_q[cl_q];
	assign stat.last_level = cl_q == LVL_FC;
	assign stat.bad_set    = (ent_cmp >= 9'(NUM_ENTRIES)) || (ns_q > LS_MAX);
	assign stat.tag_zero   = tag_q == 16'd0;
	assign stat.level      = cl_q;
endmodule

// ----- hw/rtl/mlqs_ctrl.sv -----
// ----------------------------------------------------------------------------
// mlqs_ctrl: scheduler sequencer
// Walks the task table for each operation and drives the datapath commands;
// owns the request and response handshakes.
// ----------------------------------------------------------------------------
module mlqs_ctrl #(
	parameter int NUM_ENTRIES = mlqs_pkg::DEF_NUM_ENTRIES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [2:0]                     in_op,
	output logic                           out_valid,
	input  logic                           out_ready,
	input  mlqs_pkg::stat_t                stat,
	output mlqs_pkg::cmd_t                 cmd,
	output logic [$clog2(NUM_ENTRIES)-1:0] scan_idx
);
	import mlqs_pkg::*;

	localparam int IW = $clog2(NUM_ENTRIES);

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_DISP    = 5'd1;
	localparam logic [4:0] S_AGE_RD  = 5'd2;
	localparam logic [4:0] S_AGE_EV  = 5'd3;
	localparam logic [4:0] S_Y_RD    = 5'd4;
	localparam logic [4:0] S_Y_EV    = 5'd5;
	localparam logic [4:0] S_LVL     = 5'd6;
	localparam logic [4:0] S_LVL2    = 5'd7;
	localparam logic [4:0] S_ST0_RD  = 5'd8;
	localparam logic [4:0] S_ST0_EV  = 5'd9;
	localparam logic [4:0] S_RR_RD   = 5'd10;
	localparam logic [4:0] S_RR_EV   = 5'd11;
	localparam logic [4:0] S_STK_RD  = 5'd12;
	localparam logic [4:0] S_STK_EV  = 5'd13;
	localparam logic [4:0] S_MK_RD   = 5'd14;
	localparam logic [4:0] S_MK_EV   = 5'd15;
	localparam logic [4:0] S_MK_END  = 5'd16;
	localparam logic [4:0] S_LOT_A   = 5'd17;
	localparam logic [4:0] S_LOT_B   = 5'd18;
	localparam logic [4:0] S_LOT_C   = 5'd19;
	localparam logic [4:0] S_MA_RD   = 5'd20;
	localparam logic [4:0] S_MA_EV   = 5'd21;
	localparam logic [4:0] S_MISS    = 5'd22;
	localparam logic [4:0] S_G_RD    = 5'd23;
	localparam logic [4:0] S_G_EV    = 5'd24;
	localparam logic [4:0] S_SS_RD   = 5'd25;
	localparam logic [4:0] S_SS_EV   = 5'd26;
	localparam logic [4:0] S_FIND_RD = 5'd27;
	localparam logic [4:0] S_FIND_EV = 5'd28;
	localparam logic [4:0] S_NF      = 5'd29;
	localparam logic [4:0] S_UP_RD   = 5'd30;
	localparam logic [4:0] S_UP_EV   = 5'd31;

	logic [4:0]    state_q, state_d;
	logic [IW-1:0] idx_q, idx_d;
	logic [2:0]    op_q;
	logic          fin_q, fin_d;
	logic          out_valid_q;
	logic          last_idx;

	assign last_idx = idx_q == IW'(NUM_ENTRIES - 1);
	assign scan_idx = idx_q;
	assign in_ready = (state_q == S_IDLE) && !fin_q;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		idx_d   = idx_q;
		fin_d   = fin_q;
		if (fin_q) begin
			// The result leaves once the output register is free.
			if (!out_valid_q || out_ready) begin
				cmd.emit = 1'b1;
				fin_d    = 1'b0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd.load = 1'b1;
						state_d  = S_DISP;
					end
				end
				S_DISP: begin
					idx_d = '0;
					case (op_q)
						OP_TICK: begin
							cmd.act = ACT_TICK;
							state_d = S_AGE_RD;
						end
						OP_SCHEDULE: begin
							if (stat.run_valid) begin
								cmd.act = ACT_BAD;
								fin_d   = 1'b1;
								state_d = S_IDLE;
							end else begin
								state_d = S_LVL;
							end
						end
						OP_SET_STATE: begin
							if (stat.bad_set) begin
								cmd.act = ACT_BAD;
								fin_d   = 1'b1;
								state_d = S_IDLE;
							end else begin
								state_d = S_SS_RD;
							end
						end
						OP_SET_BURST: state_d = S_FIND_RD;
						OP_SET_QUEUE: begin
							if (stat.tag_zero) begin
								cmd.act = ACT_BAD;
								fin_d   = 1'b1;
								state_d = S_IDLE;
							end else begin
								state_d = S_FIND_RD;
							end
						end
						default: begin
							cmd.act = ACT_BAD;
							fin_d   = 1'b1;
							state_d = S_IDLE;
						end
					endcase
				end
				S_AGE_RD: begin
					cmd.rd   = 1'b1;
					cmd.asel = AS_SCAN;
					state_d  = S_AGE_EV;
				end
				S_AGE_EV: begin
					cmd.act = ACT_AGE;
					if (last_idx) begin
						if (stat.run_valid) begin
							state_d = S_Y_RD;
						end else begin
							fin_d   = 1'b1;
							state_d = S_IDLE;
						end
					end else begin
						idx_d   = idx_q + 1'b1;
						state_d = S_AGE_RD;
					end
				end
				S_Y_RD: begin
					cmd.rd   = 1'b1;
					cmd.asel = AS_RUN;
					state_d  = S_Y_EV;
				end
				S_Y_EV: begin
					cmd.act = ACT_YIELD;
					fin_d   = 1'b1;
					state_d = S_IDLE;
				end
				S_LVL: begin
					cmd.act = ACT_LEVEL;
					state_d = S_LVL2;
				end
				S_LVL2: begin
					cmd.act = ACT_CLEAR;
					idx_d   = '0;
					if (stat.level == LVL_RR) begin
						state_d = stat.last_valid ? S_ST0_RD : S_RR_RD;
					end else if (stat.last_valid) begin
						state_d = S_STK_RD;
					end else begin
						state_d = (stat.level == LVL_SF) ? S_MK_RD : S_MA_RD;
					end
				end
				S_ST0_RD: begin
					cmd.rd   = 1'b1;
					cmd.asel = AS_SCAN;
					state_d  = S_ST0_EV;
				end
				S_ST0_EV: begin
					cmd.act = ACT_STICKY0;
					if (stat.hit) begin
						state_d = S_G_RD;
					end else if (last_idx) begin
						idx_d   = '0;
						state_d = S_RR_RD;
					end else begin
						idx_d   = idx_q + 1'b1;
						state_d = S_ST0_RD;
					end
				end
				S_RR_RD: begin
					cmd.rd   = 1'b1;
					cmd.asel = AS_RR;
					state_d  = S_RR_EV;
				end
				S_RR_EV: begin
					cmd.act = ACT_RR;
					if (stat.hit) begin
						state_d = S_G_RD;
					end else if (last_idx) begin
						state_d = S_MISS;
					end else begin
						idx_d   = idx_q + 1'b1;
						state_d = S_RR_RD;
					end
				end
				S_STK_RD: begin
					cmd.rd   = 1'b1;
					cmd.asel = AS_SCAN;
					state_d  = S_STK_EV;
				end
				S_STK_EV: begin
					cmd.act = ACT_STICKY;
					if (stat.hit) begin
						state_d = S_G_RD;
					end else if (last_idx) begin
						idx_d   = '0;
						state_d = (stat.level == LVL_SF) ? S_MK_RD : S_MA_RD;
					end else begin
						idx_d   = idx_q + 1'b1;
						state_d = S_STK_RD;
					end
				end
				S_MK_RD: begin
					cmd.rd   = 1'b1;
					cmd.asel = AS_SCAN;
					state_d  = S_MK_EV;
				end
				S_MK_EV: begin
					cmd.act = ACT_MINKEY;
					if (last_idx) begin
						state_d = S_MK_END;
					end else begin
						idx_d   = idx_q + 1'b1;
						state_d = S_MK_RD;
					end
				end
				S_MK_END: begin
					// A candidate found goes to the lottery; out of candidates, the last one drawn takes the slot.
					if (stat.found) begin
						state_d = S_LOT_A;
					end else if (stat.prev_valid) begin
						cmd.act = ACT_USE_PREV;
						state_d = S_G_RD;
					end else begin
						state_d = S_MISS;
					end
				end
				S_LOT_A: begin
					cmd.act = ACT_LOT_A;
					state_d = S_LOT_B;
				end
				S_LOT_B: begin
					cmd.act = ACT_LOT_B;
					state_d = S_LOT_C;
				end
				S_LOT_C: begin
					if (stat.win) begin
						state_d = S_G_RD;
					end else begin
						cmd.act = ACT_NEXT_CAND;
						idx_d   = '0;
						state_d = S_MK_RD;
					end
				end
				S_MA_RD: begin
					cmd.rd   = 1'b1;
					cmd.asel = AS_SCAN;
					state_d  = S_MA_EV;
				end
				S_MA_EV: begin
					cmd.act = ACT_MINARR;
					if (last_idx) begin
						state_d = stat.found ? S_G_RD : S_MISS;
					end else begin
						idx_d   = idx_q + 1'b1;
						state_d = S_MA_RD;
					end
				end
				S_MISS: begin
					cmd.act = ACT_MISS;
					if (stat.last_level) begin
						fin_d   = 1'b1;
						state_d = S_IDLE;
					end else begin
						state_d = S_LVL;
					end
				end
				S_G_RD: begin
					cmd.rd   = 1'b1;
					cmd.asel = AS_BEST;
					state_d  = S_G_EV;
				end
				S_G_EV: begin
					cmd.act = ACT_GRANT;
					fin_d   = 1'b1;
					state_d = S_IDLE;
				end
				S_SS_RD: begin
					cmd.rd   = 1'b1;
					cmd.asel = AS_INPUT;
					state_d  = S_SS_EV;
				end
				S_SS_EV: begin
					cmd.act = ACT_SET_STATE;
					fin_d   = 1'b1;
					state_d = S_IDLE;
				end
				S_FIND_RD: begin
					cmd.rd   = 1'b1;
					cmd.asel = AS_SCAN;
					state_d  = S_FIND_EV;
				end
				S_FIND_EV: begin
					cmd.act = ACT_FIND;
					if (stat.hit) begin
						state_d = S_UP_RD;
					end else if (last_idx) begin
						state_d = S_NF;
					end else begin
						idx_d   = idx_q + 1'b1;
						state_d = S_FIND_RD;
					end
				end
				S_NF: begin
					cmd.act = ACT_NOT_FOUND;
					fin_d   = 1'b1;
					state_d = S_IDLE;
				end
				S_UP_RD: begin
					cmd.rd   = 1'b1;
					cmd.asel = AS_BEST;
					state_d  = S_UP_EV;
				end
				S_UP_EV: begin
					cmd.act = (op_q == OP_SET_BURST) ? ACT_SET_BURST : ACT_SET_QUEUE;
					fin_d   = 1'b1;
					state_d = S_IDLE;
				end
				default: state_d = S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			op_q        <= OP_TICK;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			fin_q   <= fin_d;
			if (cmd.load) begin
				op_q <= in_op;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

// ----- hw/rtl/multilevel_queue_scheduler.sv -----
// ----------------------------------------------------------------------------
// multilevel_queue_scheduler: three-level feedback queue task scheduler
// Task table with round robin, shortest burst first and first come first
// served levels, timer aging and slice based yield.
// ----------------------------------------------------------------------------
// One operation is in flight at a time. The task table sits in a record memory
// with one write and one read port, and every entry visited is read, then
// updated. A tick walks the whole table, set state visits one entry, and set
// burst or set queue search the table for the tag before the update. A schedule
// makes one or two table passes per level tried, and on the shortest first
// level one extra pass plus a lottery draw for each candidate drawn. The
// response sits in an output register, so a new request is taken while the
// previous response waits. After reset the table reads as all unused without
// any clearing pass.
module multilevel_queue_scheduler #(
	parameter int NUM_ENTRIES = mlqs_pkg::DEF_NUM_ENTRIES
) (
	input  logic       clk,
	input  logic       arst_n,
	mlqs_req_if.sink   req,
	mlqs_rsp_if.source rsp,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import mlqs_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	logic [$clog2(NUM_ENTRIES)-1:0] scan_idx;

	mlqs_ctrl #(.NUM_ENTRIES(NUM_ENTRIES)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.in_op     (req.operation),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd),
		.scan_idx  (scan_idx)
	);

	mlqs_dp #(.NUM_ENTRIES(NUM_ENTRIES)) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.scan_idx         (scan_idx),
		.stat             (stat),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.entry            (req.entry),
		.task_tag         (req.task_tag),
		.new_state        (req.new_state),
		.burst_value      (req.burst_value),
		.confidence_value (req.confidence_value),
		.queue_value      (req.queue_value),
		.grant_valid      (rsp.grant_valid),
		.grant_entry      (rsp.grant_entry),
		.grant_tag        (rsp.grant_tag),
		.grant_level      (rsp.grant_level),
		.yield_now        (rsp.yield_now),
		.status           (rsp.status)
	);

`ifndef ASSERT_OFF
	// A new result never overwrites one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!rsp.valid || rsp.ready))
		else $error("response overwritten before it was taken");

	// Only one operation is worked on at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while another is in flight");

	// A grant and a yield never share a response, and a grant is always ok.
	a_grant_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.grant_valid) |-> (!rsp.yield_now && rsp.status == STAT_OK))
		else $error("grant response carries yield or error");
`endif
endmodule

// ----- dv/multilevel_queue_scheduler_test.sv -----
// ----------------------------------------------------------------------------
// multilevel_queue_scheduler_test: self-checking testbench of the scheduler
// A driver pushes scheduler operations from a queue of pending requests and a
// monitor predicts each accepted request with a cycle-free model of the task
// table, then checks every response beat field by field, in order. The run
// goes through directed corner cases, random task lifecycles under several
// slice settings, and random idling on both sides.
// ----------------------------------------------------------------------------
module multilevel_queue_scheduler_test;
	import mlqs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NE = DEF_NUM_ENTRIES;
	localparam logic [2:0] OP_UNDEFINED = 3'd5;
	localparam logic [2:0] LS_SLEEPING  = 3'd2;
	localparam logic [2:0] LS_ZOMBIE    = LS_MAX;
	localparam logic [2:0] LS_ILLEGAL   = 3'd6;
	localparam logic [15:0] TAG_BASE    = 16'h0100;

	typedef struct packed {
		logic [2:0]  operation;
		logic [5:0]  entry;
		logic [15:0] task_tag;
		logic [2:0]  new_state;
		logic [15:0] burst_value;
		logic [6:0]  confidence_value;
		logic [1:0]  queue_value;
	} sched_req_t;

	typedef struct packed {
		logic        grant_valid;
		logic [5:0]  grant_entry;
		logic [15:0] grant_tag;
		logic [1:0]  grant_level;
		logic        yield_now;
		logic [1:0]  status;
	} sched_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	mlqs_req_if req ();
	mlqs_rsp_if rsp ();

	multilevel_queue_scheduler u_dut (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow copy of the task table and scheduler state.
	logic [2:0]  life [NE];
	logic [15:0] tags [NE];
	logic [1:0]  levels [NE];
	logic [9:0]  waits [NE];
	logic [6:0]  confs [NE];
	logic [15:0] bursts [NE];
	logic [2:0]  streaks [NE];
	logic [31:0] arrivals [NE];
	logic [31:0] ticks;
	logic [31:0] lottery_seed;
	logic [5:0]  rr_ptr;
	logic        last_ok [NUM_LEVELS];
	logic [15:0] last_tags [NUM_LEVELS];
	logic [1:0]  level_now;
	logic [15:0] level_runs;
	logic        have_running;
	logic [5:0]  running_idx;
	logic [7:0]  slice_regs [CFG_COUNT];

	sched_req_t pending_reqs[$];
	sched_rsp_t expected_rsps[$];
	int queued_count = 0;
	int taken_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_requests = 0;
	logic req_taken = 1'b0;
	bit failed = 0;

	function automatic void reset_entry(int e, logic [1:0] lvl);
		levels[e] = lvl;
		waits[e] = '0;
		confs[e] = CONF_INIT;
		bursts[e] = BURST_INIT;
		streaks[e] = '0;
		arrivals[e] = ticks;
	endfunction

	function automatic void reset_shadow();
		ticks = '0;
		for (int e = 0; e < NE; e++) begin
			life[e] = LS_UNUSED;
			tags[e] = '0;
			reset_entry(e, LVL_RR);
		end
		lottery_seed = 32'd1;
		rr_ptr = '0;
		for (int l = 0; l < NUM_LEVELS; l++) begin
			last_ok[l] = 1'b0;
			last_tags[l] = '0;
		end
		level_now = LVL_FC;
		level_runs = '0;
		have_running = 1'b0;
		running_idx = '0;
		slice_regs[CFG_BASE_SLICE] = 8'd1;
		slice_regs[CFG_W_RR] = 8'd3;
		slice_regs[CFG_W_SF] = 8'd2;
		slice_regs[CFG_W_FC] = 8'd1;
	endfunction

	function automatic bit ready_at(int e, logic [1:0] lvl);
		return life[e] == LS_RUNNABLE && levels[e] == lvl;
	endfunction

	function automatic int sticky_pick(logic [1:0] lvl);
		if (!last_ok[lvl])
			return -1;
		for (int e = 0; e < NE; e++)
			if (ready_at(e, lvl) && tags[e] == last_tags[lvl])
				return e;
		return -1;
	endfunction

	function automatic int pick_round_robin();
		if (last_ok[LVL_RR]) begin
			for (int e = 0; e < NE; e++) begin
				if (tags[e] != last_tags[LVL_RR])
					continue;
				if (streaks[e] == STREAK_LIMIT) begin
					streaks[e] = '0;
					continue;
				end
				if (ready_at(e, LVL_RR))
					return e;
			end
		end
		for (int i = 0; i < NE; i++) begin
			rr_ptr = rr_ptr + 6'd1;
			if (ready_at(int'(rr_ptr), LVL_RR))
				return int'(rr_ptr);
		end
		return -1;
	endfunction

	function automatic int pick_shortest();
		int order [NE];
		int n;
		int j;
		int s;
		logic [31:0] draw;
		n = 0;
		s = sticky_pick(LVL_SF);
		if (s >= 0)
			return s;
		for (int e = 0; e < NE; e++) begin
			if (!ready_at(e, LVL_SF))
				continue;
			j = n;
			while (j > 0 && bursts[order[j - 1]] > bursts[e]) begin
				order[j] = order[j - 1];
				j--;
			end
			order[j] = e;
			n++;
		end
		for (int i = 0; i < n; i++) begin
			draw = ((lottery_seed >> 16) % 32'd32768) % 32'd100;
			lottery_seed = (lottery_seed + ticks) * LCG_MUL + LCG_INC;
			if (draw < confs[order[i]])
				return order[i];
		end
		return n > 0 ? order[n - 1] : -1;
	endfunction

	function automatic int pick_oldest();
		int best;
		best = sticky_pick(LVL_FC);
		if (best >= 0)
			return best;
		for (int e = 0; e < NE; e++)
			if (ready_at(e, LVL_FC) && (best < 0 || arrivals[e] < arrivals[best]))
				best = e;
		return best;
	endfunction

	function automatic int find_live_tag(logic [15:0] t);
		for (int e = 0; e < NE; e++)
			if (life[e] != LS_UNUSED && tags[e] == t)
				return e;
		return -1;
	endfunction

	// Applies one accepted operation to the shadow state and returns its response.
	function automatic sched_rsp_t predict_outcome(sched_req_t r);
		sched_rsp_t o;
		int pick;
		int f;
		logic [1:0] lvl;
		logic [15:0] slice;
		logic y;
		o = '0;
		case (r.operation)
			OP_TICK: begin
				ticks = ticks + 32'd1;
				for (int e = 0; e < NE; e++) begin
					if (life[e] != LS_RUNNABLE)
						continue;
					if (waits[e] != WAIT_MAX)
						waits[e] = waits[e] + 10'd1;
					if (waits[e] >= AGE_LIMIT && levels[e] != LVL_RR) begin
						levels[e] = levels[e] - 2'd1;
						arrivals[e] = ticks;
						waits[e] = '0;
					end
				end
				if (have_running) begin
					lvl = levels[running_idx];
					level_runs = level_runs + 16'd1;
					if (lvl != LVL_NEVER) begin
						slice = slice_regs[CFG_BASE_SLICE] * slice_regs[CFG_W_RR + lvl];
						if (level_runs == slice) begin
							level_runs = '0;
							y = 1'b1;
						end else begin
							y = lvl == LVL_RR && streaks[running_idx] == STREAK_LIMIT;
						end
					end else begin
						y = 1'b1;
					end
					if (y) begin
						life[running_idx] = LS_RUNNABLE;
						have_running = 1'b0;
						o.yield_now = 1'b1;
					end else if (streaks[running_idx] != STREAK_MAX) begin
						streaks[running_idx] = streaks[running_idx] + 3'd1;
					end
				end
			end
			OP_SCHEDULE: begin
				if (have_running) begin
					o.status = STAT_BAD_ARG;
					return o;
				end
				forever begin
					if (level_runs == 0)
						level_now = level_now == LVL_FC ? LVL_RR : level_now + 2'd1;
					case (level_now)
						LVL_RR: pick = pick_round_robin();
						LVL_SF: pick = pick_shortest();
						default: pick = pick_oldest();
					endcase
					if (pick < 0) begin
						last_ok[level_now] = 1'b0;
						level_runs = '0;
						if (level_now == LVL_FC)
							return o;
						continue;
					end
					last_ok[level_now] = 1'b1;
					last_tags[level_now] = tags[pick];
					waits[pick] = '0;
					streaks[pick] = 3'd1;
					life[pick] = LS_RUNNING;
					have_running = 1'b1;
					running_idx = 6'(pick);
					o.grant_valid = 1'b1;
					o.grant_entry = 6'(pick);
					o.grant_tag = tags[pick];
					o.grant_level = level_now;
					return o;
				end
			end
			OP_SET_STATE: begin
				if (r.new_state > LS_MAX) begin
					o.status = STAT_BAD_ARG;
				end else begin
					life[r.entry] = r.new_state;
					tags[r.entry] = r.task_tag;
					if (r.new_state == LS_EMBRYO)
						reset_entry(int'(r.entry), LVL_RR);
					else if (r.new_state == LS_UNUSED)
						reset_entry(int'(r.entry), LVL_FC);
					if (have_running && running_idx == r.entry && r.new_state != LS_RUNNING)
						have_running = 1'b0;
				end
			end
			OP_SET_BURST: begin
				f = find_live_tag(r.task_tag);
				if (f < 0) begin
					o.status = STAT_NOT_FOUND;
				end else begin
					bursts[f] = r.burst_value;
					confs[f] = r.confidence_value;
				end
			end
			OP_SET_QUEUE: begin
				f = find_live_tag(r.task_tag);
				if (r.task_tag == 0)
					o.status = STAT_BAD_ARG;
				else if (f < 0)
					o.status = STAT_NOT_FOUND;
				else if (levels[f] == r.queue_value)
					o.status = STAT_IN_QUEUE;
				else begin
					levels[f] = r.queue_value;
					arrivals[f] = ticks;
				end
			end
			default: o.status = STAT_BAD_ARG;
		endcase
		return o;
	endfunction

	// Driver: a beat stays on the bus until it is taken.
	always @(negedge clk) begin
		sched_req_t nxt;
		logic nv;
		nxt = {req.operation, req.entry, req.task_tag, req.new_state, req.burst_value,
			req.confidence_value, req.queue_value};
		nv = req.valid;
		if (!req.valid || req_taken) begin
			nv = 1'b0;
			if (arst_n && pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = pending_reqs.pop_front();
				nv = 1'b1;
			end
		end
		req.valid <= nv;
		{req.operation, req.entry, req.task_tag, req.new_state, req.burst_value,
			req.confidence_value, req.queue_value} <= nxt;
	end

	// Receiver: random stalls, plus a long hold-off when one is requested.
	always @(negedge clk) begin
		static int hold_left = 0;
		static int holds_seen = 0;
		if (holds_seen != hold_requests) begin
			holds_seen = hold_requests;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= arst_n && $urandom_range(99) >= recv_idle_pct;
		end
	end

	always @(posedge clk) begin
		sched_rsp_t got;
		sched_rsp_t exp;
		req_taken <= req.valid && req.ready;
		if (rsp.valid && rsp.ready) begin
			got = {rsp.grant_valid, rsp.grant_entry, rsp.grant_tag, rsp.grant_level,
				rsp.yield_now, rsp.status};
			if (expected_rsps.size() == 0) begin
				$error("response beat with nothing expected");
				failed = 1;
			end else begin
				exp = expected_rsps.pop_front();
				if (got.grant_valid !== exp.grant_valid) begin
					$error("grant_valid: expected %0d, got %0d", exp.grant_valid, got.grant_valid);
					failed = 1;
				end
				if (got.grant_entry !== exp.grant_entry) begin
					$error("grant_entry: expected %0d, got %0d", exp.grant_entry, got.grant_entry);
					failed = 1;
				end
				if (got.grant_tag !== exp.grant_tag) begin
					$error("grant_tag: expected %0h, got %0h", exp.grant_tag, got.grant_tag);
					failed = 1;
				end
				if (got.grant_level !== exp.grant_level) begin
					$error("grant_level: expected %0d, got %0d", exp.grant_level, got.grant_level);
					failed = 1;
				end
				if (got.yield_now !== exp.yield_now) begin
					$error("yield_now: expected %0d, got %0d", exp.yield_now, got.yield_now);
					failed = 1;
				end
				if (got.status !== exp.status) begin
					$error("status: expected %0d, got %0d", exp.status, got.status);
					failed = 1;
				end
			end
		end
		if (req.valid && req.ready) begin
			taken_count++;
			expected_rsps.push_back(predict_outcome({req.operation, req.entry, req.task_tag,
				req.new_state, req.burst_value, req.confidence_value, req.queue_value}));
		end
	end

	function automatic void add_req(logic [2:0] op, logic [5:0] e, logic [15:0] t,
			logic [2:0] ns, logic [15:0] b, logic [6:0] c, logic [1:0] q);
		pending_reqs.push_back({op, e, t, ns, b, c, q});
		queued_count++;
	endfunction

	function automatic logic [15:0] pool_tag();
		return $urandom_range(9) == 0 ? 16'($urandom) : TAG_BASE + 16'($urandom_range(15));
	endfunction

	// Mostly live task lifecycles on a small set of tags, with some noise.
	function automatic void add_random_req();
		logic [5:0] e;
		logic [15:0] t;
		int pick;
		e = $urandom_range(7) == 0 ? 6'($urandom) : 6'($urandom_range(15));
		t = $urandom_range(7) == 0 ? 16'($urandom) : TAG_BASE + e;
		pick = $urandom_range(99);
		if (pick < 35) begin
			add_req(OP_TICK, 6'($urandom), 16'($urandom), 3'($urandom), 16'($urandom),
				7'($urandom), 2'($urandom));
		end else if (pick < 60) begin
			add_req(OP_SCHEDULE, 6'($urandom), 16'($urandom), 3'($urandom), 16'($urandom),
				7'($urandom), 2'($urandom));
		end else if (pick < 75) begin
			if ($urandom_range(2) == 0) begin
				add_req(OP_SET_STATE, e, t, LS_EMBRYO, '0, '0, '0);
				add_req(OP_SET_STATE, e, t, LS_RUNNABLE, '0, '0, '0);
			end else begin
				add_req(OP_SET_STATE, e, t, $urandom_range(1) ? LS_RUNNABLE : 3'($urandom),
					16'($urandom), 7'($urandom), 2'($urandom));
			end
		end else if (pick < 85) begin
			add_req(OP_SET_BURST, 6'($urandom), pool_tag(),
				3'($urandom), $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(20)),
				$urandom_range(9) == 0 ? 7'($urandom) : 7'($urandom_range(100)), 2'($urandom));
		end else if (pick < 96) begin
			add_req(OP_SET_QUEUE, 6'($urandom), $urandom_range(19) == 0 ? 16'd0 : pool_tag(),
				3'($urandom), 16'($urandom), 7'($urandom),
				$urandom_range(9) == 0 ? LVL_NEVER : 2'($urandom_range(2)));
		end else begin
			add_req(3'($urandom_range(7, OP_UNDEFINED)), 6'($urandom), 16'($urandom),
				3'($urandom), 16'($urandom), 7'($urandom), 2'($urandom));
		end
	endfunction

	task automatic wait_drained();
		while (taken_count != queued_count || expected_rsps.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_slices(logic [7:0] base, logic [7:0] w0, logic [7:0] w1,
			logic [7:0] w2);
		logic [7:0] vals [CFG_COUNT];
		vals = '{base, w0, w1, w2};
		for (int i = 0; i < CFG_COUNT; i++) begin
			@(negedge clk);
			cfg_we <= 1'b1;
			cfg_index <= 2'(i);
			cfg_data <= vals[i];
			slice_regs[i] = vals[i];
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		req.valid = 1'b0;
		{req.operation, req.entry, req.task_tag, req.new_state, req.burst_value,
			req.confidence_value, req.queue_value} = '0;
		rsp.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_BASE_SLICE;
		cfg_data = '0;
		reset_shadow();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed corner cases on an empty and then a small table.
		add_req(OP_SCHEDULE, '0, '0, '0, '0, '0, '0);
		add_req(OP_TICK, '1, '1, '1, '1, '1, '1);
		add_req(OP_SET_BURST, '0, 16'hFFFF, '0, '1, 7'd100, '0);
		add_req(OP_SET_QUEUE, '0, '0, '0, '0, '0, LVL_SF);
		add_req(OP_SET_QUEUE, '0, 16'h7777, '0, '0, '0, LVL_SF);
		add_req(OP_SET_STATE, 6'd63, 16'hFFFF, LS_EMBRYO, '0, '0, '0);
		add_req(OP_SET_STATE, 6'd63, 16'hFFFF, LS_RUNNABLE, '0, '0, '0);
		add_req(OP_SET_STATE, 6'd0, TAG_BASE, LS_EMBRYO, '0, '0, '0);
		add_req(OP_SET_STATE, 6'd0, TAG_BASE, LS_RUNNABLE, '0, '0, '0);
		add_req(OP_SET_QUEUE, '0, TAG_BASE, '0, '0, '0, LVL_RR);
		add_req(OP_SET_QUEUE, '0, 16'hFFFF, '0, '0, '0, LVL_SF);
		add_req(OP_SET_BURST, '0, 16'hFFFF, '0, 16'hFFFF, 7'd127, '0);
		add_req(OP_SET_STATE, 6'd1, 16'h8000, LS_ILLEGAL, '0, '0, '0);
		add_req(OP_SCHEDULE, '0, '0, '0, '0, '0, '0);
		add_req(OP_SCHEDULE, '0, '0, '0, '0, '0, '0);
		for (int i = 0; i < 6; i++)
			add_req(OP_TICK, '0, '0, '0, '0, '0, '0);
		add_req(OP_SCHEDULE, '0, '0, '0, '0, '0, '0);
		add_req(OP_SET_STATE, 6'd2, 16'h0055, LS_SLEEPING, '0, '0, '0);
		add_req(OP_SET_STATE, 6'd3, 16'h00AA, LS_ZOMBIE, '0, '0, '0);
		add_req(3'd7, '1, '1, '1, '1, '1, '1);
		wait_drained();

		write_slices(8'd1, 8'd3, 8'd2, 8'd1);
		send_idle_pct = 38;
		recv_idle_pct = 53;
		for (int i = 0; i < 270; i++)
			add_random_req();
		wait_drained();

		write_slices(8'd255, 8'd255, 8'd1, 8'd128);
		send_idle_pct = 53;
		recv_idle_pct = 38;
		for (int i = 0; i < 270; i++)
			add_random_req();
		wait_drained();

		write_slices(8'd2, 8'd1, 8'd255, 8'd4);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_requests++;
		for (int i = 0; i < 260; i++)
			add_random_req();
		wait_drained();
		repeat (50) @(posedge clk);

		if (!failed)
			$display("multilevel_queue_scheduler regression: pass");
		else
			$display("multilevel_queue_scheduler regression: fail");
		$finish;
	end

	initial begin
		#100_000_000;
		$display("multilevel_queue_scheduler regression: fail");
		$finish;
	end

endmodule
